// ===== src/m4i_pkg.sv =====
package m4i_pkg;

   localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

   typedef enum logic [7:0] {
      S_LOAD    = 8'b0000_0001,
      S_FETCH_A = 8'b0000_0010,
      S_FETCH_B = 8'b0000_0100,
      S_MUL_GO  = 8'b0000_1000,
      S_MUL_WT  = 8'b0001_0000,
      S_DIV_GO  = 8'b0010_0000,
      S_DIV_WT  = 8'b0100_0000,
      S_OUT     = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } unit_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } unit_rsp_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      logic [63:0] ov;
      s  = a + b;
      ov = (a ^ s) & (b ^ s);
      if (ov[63])
         return a[63] ? S64_MIN : S64_MAX;
      return s;
   endfunction

   function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      logic [63:0] ov;
      s  = a - b;
      ov = (a ^ b) & (a ^ s);
      if (ov[63])
         return a[63] ? S64_MIN : S64_MAX;
      return s;
   endfunction

   function automatic logic [63:0] sat_neg(input logic [63:0] a);
      return (a == S64_MIN) ? S64_MAX : (64'd0 - a);
   endfunction

   // position of minor element n (row-major in the 3x3) within the 4x4
   function automatic logic [3:0] minor_index(input logic [1:0] r, input logic [1:0] c,
                                              input logic [3:0] n);
      logic [1:0] i;
      logic [1:0] j;
      logic [1:0] row;
      logic [1:0] col;
      i = 2'd0;
      j = 2'd0;
      case (n)
         4'd0: begin i = 2'd0; j = 2'd0; end
         4'd1: begin i = 2'd0; j = 2'd1; end
         4'd2: begin i = 2'd0; j = 2'd2; end
         4'd3: begin i = 2'd1; j = 2'd0; end
         4'd4: begin i = 2'd1; j = 2'd1; end
         4'd5: begin i = 2'd1; j = 2'd2; end
         4'd6: begin i = 2'd2; j = 2'd0; end
         4'd7: begin i = 2'd2; j = 2'd1; end
         4'd8: begin i = 2'd2; j = 2'd2; end
         default: begin i = 2'd0; j = 2'd0; end
      endcase
      row = (i >= r) ? i + 2'd1 : i;
      col = (j >= c) ? j + 2'd1 : j;
      return {row, col};
   endfunction

   function automatic logic [3:0] step_a_pos(input logic [3:0] step);
      case (step)
         4'd0: return 4'd4;
         4'd1: return 4'd5;
         4'd2: return 4'd3;
         4'd3: return 4'd5;
         4'd4: return 4'd3;
         4'd5: return 4'd4;
         4'd6: return 4'd0;
         4'd7: return 4'd1;
         4'd8: return 4'd2;
         default: return 4'd0;
      endcase
   endfunction

   function automatic logic [3:0] step_b_pos(input logic [3:0] step);
      case (step)
         4'd0: return 4'd8;
         4'd1: return 4'd7;
         4'd2: return 4'd8;
         4'd3: return 4'd6;
         4'd4: return 4'd7;
         4'd5: return 4'd6;
         default: return 4'd0;
      endcase
   endfunction

endpackage

// ===== src/m4i_req_if.sv =====
interface m4i_req_if #(parameter int VALUE_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic [3:0]                    element_index;
   logic signed [VALUE_WIDTH-1:0] element_value;
   logic                          last_element;

   modport source(output valid, element_index, element_value, last_element, input ready);
   modport sink(input valid, element_index, element_value, last_element, output ready);
endinterface

// ===== src/m4i_rsp_if.sv =====
interface m4i_rsp_if #(parameter int VALUE_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic [3:0]                    result_index;
   logic signed [VALUE_WIDTH-1:0] result_value;
   logic                          singular;
   logic                          last_result;

   modport source(output valid, result_index, result_value, singular, last_result,
                  input ready);
   modport sink(input valid, result_index, result_value, singular, last_result,
                output ready);
endinterface

// ===== src/m4i_mul.sv =====
module m4i_mul #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  m4i_pkg::unit_cmd_type cmd,
   output m4i_pkg::unit_rsp_type rsp
);
   import m4i_pkg::*;

   logic         run_ff;
   logic         done_ff;
   logic [2:0]   cnt_ff;
   logic         neg_ff;
   logic [63:0]  ma_ff;
   logic [63:0]  mb_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   sel_ff;
   logic [127:0] acc_ff;
   logic [63:0]  res_ff;

   logic [31:0]  a_part;
   logic [31:0]  b_part;
   logic [127:0] pp_shift;
   logic [127:0] prod;
   logic [127:0] sh;
   logic [63:0]  fin;

   assign a_part = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign b_part = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];

   always_comb begin
      case (sel_ff)
         2'd0:    pp_shift = {64'd0, pp_ff};
         2'd3:    pp_shift = {pp_ff, 64'd0};
         default: pp_shift = {32'd0, pp_ff, 32'd0};
      endcase
   end

   always_comb begin
      prod = neg_ff ? (128'd0 - acc_ff) : acc_ff;
      sh   = $signed(prod) >>> FRACTION_BITS;
      if (sh[127:64] != {64{sh[63]}})
         fin = sh[127] ? S64_MIN : S64_MAX;
      else
         fin = sh[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            run_ff <= 1'b1;
            cnt_ff <= 3'd0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         neg_ff <= cmd.a[63] ^ cmd.b[63];
         ma_ff  <= cmd.a[63] ? 64'd0 - cmd.a : cmd.a;
         mb_ff  <= cmd.b[63] ? 64'd0 - cmd.b : cmd.b;
         acc_ff <= '0;
      end else if (run_ff) begin
         if (cnt_ff < 3'd4) begin
            pp_ff  <= a_part * b_part;
            sel_ff <= cnt_ff[1:0];
         end
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4)
            acc_ff <= acc_ff + pp_shift;
         if (cnt_ff == 3'd5)
            res_ff <= fin;
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

endmodule

// ===== src/m4i_div.sv =====
module m4i_div #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  m4i_pkg::unit_cmd_type cmd,
   output m4i_pkg::unit_rsp_type rsp
);
   import m4i_pkg::*;

   localparam logic [63:0] LIMIT_NEG = 64'd1 << (VALUE_WIDTH - 1);
   localparam logic [63:0] LIMIT_POS = LIMIT_NEG - 64'd1;

   logic         run_ff;
   logic         fin_ff;
   logic         done_ff;
   logic [6:0]   cnt_ff;
   logic         neg_ff;
   logic [127:0] dv_ff;
   logic [63:0]  d_ff;
   logic [63:0]  rem_ff;
   logic [127:0] q_ff;
   logic [63:0]  res_ff;

   logic [63:0]  n_mag;
   logic [64:0]  r2;
   logic [64:0]  diff;
   logic         ge;
   logic [63:0]  limit;
   logic [63:0]  qs;

   assign n_mag = cmd.a[63] ? 64'd0 - cmd.a : cmd.a;
   assign r2    = {rem_ff, dv_ff[127]};
   assign diff  = r2 - {1'b0, d_ff};
   assign ge    = r2 >= {1'b0, d_ff};
   assign limit = neg_ff ? LIMIT_NEG : LIMIT_POS;
   assign qs    = (q_ff[127:64] != 64'd0 || q_ff[63:0] > limit) ? limit : q_ff[63:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         done_ff <= 1'b0;
         fin_ff  <= 1'b0;
         if (cmd.start) begin
            run_ff <= 1'b1;
            cnt_ff <= 7'd0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd127) begin
               run_ff <= 1'b0;
               fin_ff <= 1'b1;
            end
         end else if (fin_ff) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         neg_ff <= cmd.a[63] ^ cmd.b[63];
         dv_ff  <= {64'd0, n_mag} << FRACTION_BITS;
         d_ff   <= cmd.b[63] ? 64'd0 - cmd.b : cmd.b;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (run_ff) begin
         rem_ff <= ge ? diff[63:0] : r2[63:0];
         q_ff   <= {q_ff[126:0], ge};
         dv_ff  <= {dv_ff[126:0], 1'b0};
      end else if (fin_ff) begin
         res_ff <= neg_ff ? 64'd0 - qs : qs;
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

endmodule

// ===== src/matrix4_inverse_adjugate_top.sv =====
// 4x4 fixed-point matrix inverse by adjugate. Elements arrive one per transfer, row-major
// index with a last marker; the marked transfer starts the solve and the block then takes
// no input until all 16 inverse elements have been transferred out, row-major, the last
// one marked. All products go through one shared multiplier (four 32x32 partial products
// each, with the operands fetched before every product), 148 products in all; each of the
// 16 quotients then comes from a bit-serial divider, one at a time as outputs are taken.
// A zero determinant skips the divider and returns zeros with singular set. Loading
// costs one cycle per element.
module matrix4_inverse_adjugate_top #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   m4i_req_if.sink    req_if,
   m4i_rsp_if.source  rsp_if
);
   import m4i_pkg::*;

   state_type              state_ff, state_in;
   logic                   det_phase_ff;
   logic [3:0]             step_ff;
   logic [3:0]             cof_idx_ff;
   logic [3:0]             k_ff;
   logic                   singular_ff;
   logic [63:0]            op_a_ff;
   logic [63:0]            op_b_ff;
   logic [63:0]            tmp_ff;
   logic [63:0]            t_ff [3];
   logic [63:0]            acc_ff;
   logic [63:0]            det_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [VALUE_WIDTH-1:0] matrix_ff [16];
   logic [63:0]            cof_ff [16];

   logic [3:0]             m_addr;
   logic [3:0]             c_addr;
   logic [63:0]            mat_rd;
   logic [63:0]            cof_rd;
   logic [63:0]            p;
   logic [63:0]            fin3;
   logic [63:0]            det_next;
   logic [1:0]             t_sel;
   unit_cmd_type           mul_cmd, div_cmd;
   unit_rsp_type           mul_rsp, div_rsp;

   assign p      = mul_rsp.value;
   assign t_sel  = 2'(step_ff - 4'd6);
   assign fin3   = sat_add(acc_ff, p);
   assign det_next = sat_add(acc_ff, p);

   always_comb begin
      if (det_phase_ff)
         m_addr = step_ff;
      else if (state_ff == S_FETCH_A)
         m_addr = minor_index(cof_idx_ff[3:2], cof_idx_ff[1:0], step_a_pos(step_ff));
      else
         m_addr = minor_index(cof_idx_ff[3:2], cof_idx_ff[1:0], step_b_pos(step_ff));
   end

   assign c_addr = det_phase_ff && state_ff != S_DIV_GO ? step_ff : {k_ff[1:0], k_ff[3:2]};
   assign mat_rd = 64'(signed'(matrix_ff[m_addr]));
   assign cof_rd = cof_ff[c_addr];

   assign mul_cmd.start = state_ff == S_MUL_GO;
   assign mul_cmd.a     = op_a_ff;
   assign mul_cmd.b     = op_b_ff;
   assign div_cmd.start = state_ff == S_DIV_GO && !singular_ff;
   assign div_cmd.a     = cof_rd;
   assign div_cmd.b     = det_ff;

   m4i_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
      .clock(clock), .reset(reset), .cmd(mul_cmd), .rsp(mul_rsp)
   );

   m4i_div #(.VALUE_WIDTH(VALUE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock(clock), .reset(reset), .cmd(div_cmd), .rsp(div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_if.valid && req_if.last_element)
               state_in = S_FETCH_A;
         end
         S_FETCH_A: state_in = S_FETCH_B;
         S_FETCH_B: state_in = S_MUL_GO;
         S_MUL_GO:  state_in = S_MUL_WT;
         S_MUL_WT: begin
            if (mul_rsp.done)
               state_in = (det_phase_ff && step_ff == 4'd3) ? S_DIV_GO : S_FETCH_A;
         end
         S_DIV_GO:  state_in = singular_ff ? S_OUT : S_DIV_WT;
         S_DIV_WT: begin
            if (div_rsp.done)
               state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_if.ready)
               state_in = (k_ff == 4'd15) ? S_LOAD : S_DIV_GO;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         det_phase_ff <= 1'b0;
         step_ff      <= 4'd0;
         cof_idx_ff   <= 4'd0;
         k_ff         <= 4'd0;
         singular_ff  <= 1'b0;
         det_ff       <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_LOAD: begin
               det_phase_ff <= 1'b0;
               step_ff      <= 4'd0;
               cof_idx_ff   <= 4'd0;
               k_ff         <= 4'd0;
            end
            S_MUL_WT: begin
               if (mul_rsp.done) begin
                  if (det_phase_ff) begin
                     if (step_ff == 4'd3) begin
                        det_ff      <= det_next;
                        singular_ff <= det_next == 64'd0;
                     end else begin
                        step_ff <= step_ff + 4'd1;
                     end
                  end else if (step_ff == 4'd8) begin
                     step_ff <= 4'd0;
                     if (cof_idx_ff == 4'd15)
                        det_phase_ff <= 1'b1;
                     else
                        cof_idx_ff <= cof_idx_ff + 4'd1;
                  end else begin
                     step_ff <= step_ff + 4'd1;
                  end
               end
            end
            S_OUT: begin
               if (rsp_if.ready)
                  k_ff <= k_ff + 4'd1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD && req_if.valid)
         matrix_ff[req_if.element_index] <= req_if.element_value;
      if (state_ff == S_FETCH_A)
         op_a_ff <= mat_rd;
      if (state_ff == S_FETCH_B) begin
         if (det_phase_ff)
            op_b_ff <= cof_rd;
         else if (step_ff < 4'd6)
            op_b_ff <= mat_rd;
         else
            op_b_ff <= t_ff[t_sel];
      end
      if (state_ff == S_MUL_WT && mul_rsp.done) begin
         if (det_phase_ff) begin
            acc_ff <= det_next;
         end else begin
            case (step_ff)
               4'd0, 4'd2, 4'd4: tmp_ff  <= p;
               4'd1:             t_ff[0] <= sat_sub(tmp_ff, p);
               4'd3:             t_ff[1] <= sat_sub(tmp_ff, p);
               4'd5:             t_ff[2] <= sat_sub(tmp_ff, p);
               4'd6:             acc_ff  <= p;
               4'd7:             acc_ff  <= sat_sub(acc_ff, p);
               4'd8: begin
                  cof_ff[cof_idx_ff] <= (cof_idx_ff[2] ^ cof_idx_ff[0]) ? sat_neg(fin3) : fin3;
                  acc_ff             <= '0;
               end
               default: ;
            endcase
         end
      end
      if (state_ff == S_DIV_GO && singular_ff)
         val_ff <= '0;
      if (state_ff == S_DIV_WT && div_rsp.done)
         val_ff <= div_rsp.value[VALUE_WIDTH-1:0];
   end

   assign req_if.ready        = state_ff == S_LOAD;
   assign rsp_if.valid        = state_ff == S_OUT;
   assign rsp_if.result_index = k_ff;
   assign rsp_if.result_value = val_ff;
   assign rsp_if.singular     = singular_ff;
   assign rsp_if.last_result  = k_ff == 4'd15;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("input and output open together");

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.singular |-> rsp_if.result_value == '0)
      else $error("singular result not zero");

   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> state_ff == S_MUL_WT)
      else $error("multiplier finished outside wait");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV_WT && !singular_ff)
      else $error("divider finished outside wait");

endmodule

// ===== bench/tb_matrix4_inverse_adjugate_top.sv =====
module tb_matrix4_inverse_adjugate_top;
   import m4i_pkg::*;

   localparam int VW = 32;
   localparam int FB = 16;
   localparam int LIMIT = 5_000_000;

   typedef struct {
      logic [3:0]    index;
      logic [VW-1:0] value;
      logic          singular;
      logic          last;
   } inv_elem_type;

   class inverse_scoreboard;
      logic [63:0]  elements[16];
      inv_elem_type pending[$];
      int           errors;

      function new();
         errors = 0;
         foreach (elements[i]) elements[i] = '0;
      endfunction

      function logic [63:0] q_add(logic [63:0] a, logic [63:0] b);
         logic [63:0] s;
         s = a + b;
         if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
         return s;
      endfunction

      function logic [63:0] q_sub(logic [63:0] a, logic [63:0] b);
         logic [63:0] s;
         s = a - b;
         if (a[63] != b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
         return s;
      endfunction

      function logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
         logic signed [127:0] p;
         p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
         p = p >>> FB;
         if ((&p[127:63]) || !(|p[127:63])) return p[63:0];
         return p[127] ? S64_MIN : S64_MAX;
      endfunction

      function logic [VW-1:0] q_div(logic [63:0] num, logic [63:0] den);
         logic          neg;
         logic [63:0]   n, d;
         logic [127:0]  q, lim;
         neg = num[63] ^ den[63];
         n   = num[63] ? -num : num;
         d   = den[63] ? -den : den;
         q   = ({64'd0, n} << FB) / {64'd0, d};
         lim = (128'd1 << (VW - 1)) - (neg ? 128'd0 : 128'd1);
         if (q > lim) q = lim;
         return neg ? VW'(-q) : VW'(q);
      endfunction

      function logic [63:0] minor_det(int r, int c);
         logic [63:0] x[9];
         logic [63:0] t0, t1, t2, s;
         int          n;
         n = 0;
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
               if (i != r && j != c) begin
                  x[n] = elements[i*4+j];
                  n++;
               end
         t0 = q_sub(q_mul(x[4], x[8]), q_mul(x[5], x[7]));
         t1 = q_sub(q_mul(x[3], x[8]), q_mul(x[5], x[6]));
         t2 = q_sub(q_mul(x[3], x[7]), q_mul(x[4], x[6]));
         s  = q_sub(q_mul(x[0], t0), q_mul(x[1], t1));
         return q_add(s, q_mul(x[2], t2));
      endfunction

      function void note_input(logic [3:0] idx, logic [VW-1:0] val, logic last);
         logic [63:0]  cof[16];
         logic [63:0]  d, det;
         inv_elem_type e;
         elements[idx] = {{(64-VW){val[VW-1]}}, val};
         if (!last) return;
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
               d = minor_det(r, c);
               if ((r + c) % 2) d = (d == S64_MIN) ? S64_MAX : -d;
               cof[r*4+c] = d;
            end
         det = '0;
         for (int c = 0; c < 4; c++) det = q_add(det, q_mul(elements[c], cof[c]));
         for (int k = 0; k < 16; k++) begin
            e.index    = k[3:0];
            e.singular = (det == 0);
            e.value    = e.singular ? '0 : q_div(cof[(k%4)*4 + k/4], det);
            e.last     = (k == 15);
            pending.push_back(e);
         end
      endfunction

      function void check(logic [3:0] idx, logic [VW-1:0] val, logic sing, logic last);
         inv_elem_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result idx=%0d value=%h", $time, idx, val);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (idx !== e.index || val !== e.value || sing !== e.singular || last !== e.last) begin
            $display("%0t: mismatch expected idx=%0d value=%h sing=%b last=%b",
                     $time, e.index, e.value, e.singular, e.last);
            $display("%0t:          actual   idx=%0d value=%h sing=%b last=%b",
                     $time, idx, val, sing, last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles;
   bit   calm;
   inverse_scoreboard sb;

   m4i_req_if #(.VALUE_WIDTH(VW)) req_if();
   m4i_rsp_if #(.VALUE_WIDTH(VW)) rsp_if();

   matrix4_inverse_adjugate_top #(.VALUE_WIDTH(VW), .FRACTION_BITS(FB)) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int pick_gap();
      int p;
      if (calm) return 0;
      p = $urandom_range(0, 99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [VW-1:0] pick_value();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return VW'($urandom_range(0, 393216)) - VW'(196608);
      if (p < 60) return VW'($urandom_range(0, 8)) - VW'(4) << FB;
      if (p < 75) return VW'($urandom);
      if (p < 82) return '0;
      if (p < 91) return {1'b1, {(VW-1){1'b0}}};
      return {1'b0, {(VW-1){1'b1}}};
   endfunction

   task automatic send_element(logic [3:0] idx, logic [VW-1:0] val, logic last);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.element_index <= idx;
      req_if.element_value <= val;
      req_if.last_element  <= last;
      do @(posedge clock); while (!req_if.ready);
      sb.note_input(idx, val, last);
   endtask

   task automatic send_matrix(logic [VW-1:0] m[16]);
      for (int i = 0; i < 16; i++) send_element(i[3:0], m[i], i == 15);
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm || $urandom_range(0, 99) < 60) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            repeat (pick_gap()) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check(rsp_if.result_index, rsp_if.result_value, rsp_if.singular,
                  rsp_if.last_result);
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      logic [VW-1:0] m[16];
      int            items;
      int            n;
      int            p;
      sb = new();
      cycles = 0;
      calm = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.element_index = '0;
      req_if.element_value = '0;
      req_if.last_element = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // identity, then singular, then extreme corners and a rewritten index
      foreach (m[i]) m[i] = (i % 5 == 0) ? VW'(1) << FB : '0;
      send_matrix(m);
      send_element(4'd5, '0, 1'b1);
      send_element(4'd5, VW'(2) << FB, 1'b0);
      send_element(4'd0, {1'b1, {(VW-1){1'b0}}}, 1'b1);
      send_element(4'd3, {1'b0, {(VW-1){1'b1}}}, 1'b1);
      send_element(4'd15, VW'(7), 1'b0);
      send_element(4'd15, VW'(3) << (FB - 1), 1'b1);
      drain();

      items = 0;
      while (items < 180) begin
         calm = ($urandom_range(0, 5) == 0);
         p = $urandom_range(0, 99);
         if (p < 70) begin
            foreach (m[i]) m[i] = pick_value();
            if ($urandom_range(0, 9) == 0)
               for (int j = 0; j < 4; j++) m[12+j] = m[j];
            send_matrix(m);
            items += 16;
         end else begin
            n = $urandom_range(1, 5);
            for (int j = 0; j < n; j++)
               send_element(4'($urandom_range(0, 15)), pick_value(), j == n - 1);
            items += n;
         end
         if ($urandom_range(0, 4) == 0) drain();
      end
      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
